// ----- sv/selective_repeat_receiver_macros.svh -----
// Assertion macros shared by the selective-repeat receiver modules.
`ifndef SELECTIVE_REPEAT_RECEIVER_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SRR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SRR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/srr_pkg.sv -----
// Shared constants and types of the selective-repeat receiver.
`timescale 1ns / 1ps
package srr_pkg;

    localparam int SEQ_SPACE    = 16;
    localparam int SEQ_W        = 4;
    localparam int WINDOW_SIZE  = 8;
    localparam int PAYLOAD_BITS = 64;
    localparam int PAYLOAD_W    = 64;

    // effective window, capped at the sequence space
    localparam int WIN   = (WINDOW_SIZE < SEQ_SPACE) ? WINDOW_SIZE : SEQ_SPACE;
    localparam int CNT_W = $clog2(WIN + 1);

    localparam int IN_DATA_W  = ((SEQ_W + PAYLOAD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((SEQ_W + PAYLOAD_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0]        seq;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_pkt;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- sv/srr_front.sv -----
// Input side: accept packets, drop corrupt ones, push good ones to the queue.
`timescale 1ns / 1ps
module srr_front (
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [srr_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  logic                    i_s_tuser,
    input  srr_pkg::t_q_stat        i_q_stat,
    output logic                    o_push,
    output srr_pkg::t_pkt           o_pkt
);
    import srr_pkg::*;

    logic w_accept;

    // a corrupt packet is taken and dropped, so the port only waits on a full queue
    assign o_s_tready = !i_q_stat.full;
    assign w_accept   = i_s_tvalid && !i_q_stat.full;
    assign o_push     = w_accept && i_s_tuser;

    assign o_pkt.seq     = i_s_tdata[SEQ_W-1:0];
    assign o_pkt.payload = i_s_tdata[SEQ_W +: PAYLOAD_BITS];

endmodule

// ----- sv/srr_queue.sv -----
// Short packet queue between the input side and the window engine.
`timescale 1ns / 1ps
`include "selective_repeat_receiver_macros.svh"
module srr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  srr_pkg::t_pkt    i_pkt,
    input  logic             i_pop,
    output srr_pkg::t_pkt    o_pkt,
    output srr_pkg::t_q_stat o_stat
);
    import srr_pkg::*;

    t_pkt              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_pkt        = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_pkt;
        end
    end

    `SRR_ASSERT_IMP(a_no_push_full, i_push, !o_stat.full, "push into full queue")
    `SRR_ASSERT_IMP(a_cnt_range, 1'b1, r_cnt <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
    `SRR_ASSERT_NXT(a_push_fills, i_push && !i_pop, !o_stat.empty, "pushed word vanished")

endmodule

// ----- sv/srr_back.sv -----
// Window engine: classify queued packets, buffer payloads, emit acks and in-order deliveries.
`timescale 1ns / 1ps
`include "selective_repeat_receiver_macros.svh"
module srr_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  srr_pkg::t_pkt                  i_pkt,
    input  srr_pkg::t_q_stat               i_q_stat,
    output logic                           o_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [srr_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                           o_m_tuser,
    output logic                           o_m_tlast
);
    import srr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WAIT = 2'd1;
    localparam logic [1:0] S_SEND = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [SEQ_W-1:0]        r_base, n_base;
    logic [SEQ_SPACE-1:0]    r_filled, n_filled;
    logic [SEQ_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_ov, n_ov;
    logic                    r_kind, n_kind;
    logic [SEQ_W-1:0]        r_ack, n_ack;
    logic [PAYLOAD_BITS-1:0] r_pay, n_pay;
    logic                    r_last, n_last;

    logic [PAYLOAD_BITS-1:0] r_slot [SEQ_SPACE];
    logic [PAYLOAD_BITS-1:0] r_rd;
    logic                    w_we;

    logic                    w_free;
    logic [SEQ_W-1:0]        w_dist;
    logic                    w_in_win;
    logic                    w_in_prev;
    logic [SEQ_W-1:0]        w_nxt;
    logic                    w_end;

    assign w_free    = !r_ov || i_m_tready;
    assign w_dist    = i_pkt.seq - r_base;
    assign w_in_win  = ({1'b0, w_dist} < (SEQ_W + 1)'(WIN));
    assign w_in_prev = ({1'b0, w_dist} >= (SEQ_W + 1)'(SEQ_SPACE - WIN));
    assign w_nxt     = r_idx + 1'b1;
    assign w_end     = (r_cnt == CNT_W'(WIN - 1)) || !r_filled[w_nxt];

    always_comb begin
        n_state  = r_state;
        n_base   = r_base;
        n_filled = r_filled;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_ov     = r_ov;
        n_kind   = r_kind;
        n_ack    = r_ack;
        n_pay    = r_pay;
        n_last   = r_last;
        o_pop    = 1'b0;
        w_we     = 1'b0;
        if (r_ov && i_m_tready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty && w_free) begin
                    o_pop = 1'b1;
                    if (w_in_win) begin
                        // keep the first copy of a duplicate
                        w_we = !r_filled[i_pkt.seq];
                        n_filled[i_pkt.seq] = 1'b1;
                        n_ov   = 1'b1;
                        n_kind = KIND_ACK;
                        n_ack  = i_pkt.seq;
                        n_pay  = '0;
                        n_last = (i_pkt.seq != r_base);
                        if (i_pkt.seq == r_base) begin
                            n_idx   = i_pkt.seq;
                            n_cnt   = '0;
                            n_state = S_WAIT;
                        end
                    end else if (w_in_prev) begin
                        n_ov   = 1'b1;
                        n_kind = KIND_ACK;
                        n_ack  = i_pkt.seq;
                        n_pay  = '0;
                        n_last = 1'b1;
                    end
                end
            end
            S_WAIT: begin
                // slot write lands; the read issued now sees it
                n_state = S_SEND;
            end
            S_SEND: begin
                if (w_free) begin
                    n_ov   = 1'b1;
                    n_kind = KIND_DELIVER;
                    n_ack  = '0;
                    n_pay  = r_rd;
                    n_last = w_end;
                    n_filled[r_idx] = 1'b0;
                    n_idx  = w_nxt;
                    if (w_end) begin
                        n_base  = w_nxt;
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_base   <= '0;
            r_filled <= '0;
            r_ov     <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_base   <= n_base;
            r_filled <= n_filled;
            r_ov     <= n_ov;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_kind <= n_kind;
        r_ack  <= n_ack;
        r_pay  <= n_pay;
        r_last <= n_last;
    end

    // payload buffer: one write port, one registered read at the next index
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_slot[i_pkt.seq] <= i_pkt.payload;
        end
        r_rd <= r_slot[n_idx];
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = OUT_DATA_W'({r_pay, r_ack});

    `SRR_ASSERT_IMP(a_pop_nonempty, o_pop, !i_q_stat.empty, "pop from empty queue")
    `SRR_ASSERT_IMP(a_send_filled, r_state == S_SEND, r_filled[r_idx], "delivering empty slot")
    `SRR_ASSERT_IMP(a_send_cap, r_state == S_SEND, r_cnt < CNT_W'(WIN), "delivery run too long")
    `SRR_ASSERT_IMP(a_wait_ack, r_state == S_WAIT, r_ov && r_kind == KIND_ACK && !r_last,
                    "ack before delivery missing")

endmodule

// ----- sv/selective_repeat_receiver.sv -----
// Top level of the selective-repeat ARQ receiver.
`timescale 1ns / 1ps
// Selective-repeat ARQ receiver. Each input word is one arriving packet:
// tuser carries the upstream checksum flag, tdata the sequence number and
// the payload. A packet with a bad checksum is taken and dropped with no
// output. A packet inside the receive window [base, base+8) mod 16 is acked
// and its payload buffered (a duplicate keeps the first copy); if its number
// equals the base, the ack is followed by the run of consecutive buffered
// payloads from the base on, and the base moves past them. A packet in the
// previous window is acked again only; anything else is dropped silently.
// Output words carry tuser = 0 for an ack (sequence number in tdata) and
// tuser = 1 for a delivered payload; tlast marks the final word caused by
// one packet. Timing: a two-word queue decouples the input port, so packets
// are taken while the engine works. The engine handles one packet at a time:
// a packet that gives an ack or nothing is handled in IDLE alone, and a
// packet that opens a delivery run passes IDLE (the ack), WAIT (a turnaround
// so the payload buffer write lands before the registered read) and SEND
// (one payload per cycle). The output register lets the engine go on as
// long as the downstream side takes words; a stall holds it.
module selective_repeat_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave side: one arriving packet per word
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata: [3:0] seq_num, [67:4] payload, [71:68] zero
    input  logic [srr_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: [0] checksum_ok
    input  logic                           i_s_tuser,
    // master side: acks and delivered payloads
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata: [3:0] ack_num, [67:4] payload_out, [71:68] zero
    output logic [srr_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // tuser: [0] kind (0 ack, 1 delivered payload)
    output logic                           o_m_tuser,
    // tlast: final word for the packet
    output logic                           o_m_tlast
);
    import srr_pkg::*;

    t_q_stat w_q_stat;
    t_pkt    w_push_pkt;
    t_pkt    w_head_pkt;
    logic    w_push;
    logic    w_pop;

    // input side: accept and filter on checksum
    srr_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_pkt      (w_push_pkt)
    );

    // decoupling queue for good packets
    srr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pkt   (w_push_pkt),
        .i_pop   (w_pop),
        .o_pkt   (w_head_pkt),
        .o_stat  (w_q_stat)
    );

    // window engine: classify, buffer, ack and deliver in order
    srr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pkt      (w_head_pkt),
        .i_q_stat   (w_q_stat),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ----- tb/selective_repeat_receiver_test.sv -----
// Self-checking testbench for the selective-repeat ARQ receiver.
`timescale 1ns / 1ps
module selective_repeat_receiver_test;
    import srr_pkg::*;

    localparam int PAD_W        = IN_DATA_W - SEQ_W - PAYLOAD_W;
    localparam int OUT_PAD_W    = OUT_DATA_W - SEQ_W - PAYLOAD_W;
    // settle margin sized from the longest delivery run and the input queue depth
    localparam int DRAIN_SETTLE = 2 * (WIN + 2) + QUEUE_DEPTH + 4;
    localparam int MAX_PRINTS   = 40;

    typedef struct {
        logic                 kind;
        logic [SEQ_W-1:0]     ack_num;
        logic [PAYLOAD_W-1:0] data;
        logic                 last;
    } t_rx_word;

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tready = 1'b0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;

    selective_repeat_receiver i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Receiver-side mirror: window base, slot flags and buffered payloads.
    int                   rx_base;
    bit                   slot_full [SEQ_SPACE];
    logic [PAYLOAD_W-1:0] slot_word [SEQ_SPACE];

    // Words the block still owes, oldest first.
    t_rx_word pending_words[$];

    int error_count   = 0;
    int items_taken   = 0;
    int corrupt_taken = 0;
    int acks_seen     = 0;
    int payloads_seen = 0;

    // Sender pacing and receiver stall pattern.
    bit       pacing_on  = 1'b0;
    int       burst_left = 0;
    int       rx_mode    = 0;
    bit [7:0] stall_pattern = 8'hFF;

    task automatic report_mismatch(input string what, input logic [PAYLOAD_W-1:0] got,
                                   input logic [PAYLOAD_W-1:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    endtask

    // Work out every word one accepted packet causes and queue them.
    function automatic void predict_packet(input logic ok, input logic [SEQ_W-1:0] seq,
                                           input logic [PAYLOAD_W-1:0] pay);
        t_rx_word w;
        int       delta;
        int       idx;
        if (!ok)
            return;
        delta = (int'(seq) + SEQ_SPACE - rx_base) % SEQ_SPACE;
        if (delta < WIN) begin
            if (!slot_full[seq]) begin
                slot_word[seq] = pay;
                slot_full[seq] = 1'b1;
            end
            w.kind    = KIND_ACK;
            w.ack_num = seq;
            w.data    = '0;
            w.last    = !(int'(seq) == rx_base && slot_full[rx_base]);
            pending_words.push_back(w);
            if (int'(seq) == rx_base) begin
                idx = rx_base;
                for (int n = 0; n < WIN && slot_full[idx]; n++) begin
                    w.kind    = KIND_DELIVER;
                    w.ack_num = '0;
                    w.data    = slot_word[idx];
                    slot_full[idx] = 1'b0;
                    idx = (idx + 1) % SEQ_SPACE;
                    w.last    = !((n + 1 < WIN) && slot_full[idx]);
                    pending_words.push_back(w);
                end
                rx_base = idx;
            end
        end else if (delta >= SEQ_SPACE - WIN) begin
            w.kind    = KIND_ACK;
            w.ack_num = seq;
            w.data    = '0;
            w.last    = 1'b1;
            pending_words.push_back(w);
        end
    endfunction

    function automatic logic [PAYLOAD_W-1:0] random_payload();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Insert a random gap once the current burst runs out.
    task automatic pace_sender;
        int gap;
        if (!pacing_on)
            return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic send_packet(input logic ok, input logic [SEQ_W-1:0] seq,
                               input logic [PAYLOAD_W-1:0] pay);
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= ok;
        s_tdata  <= {{PAD_W{1'b0}}, pay, seq};
        do @(posedge i_clk); while (!o_s_tready);
        predict_packet(ok, seq, pay);
        items_taken++;
        if (!ok)
            corrupt_taken++;
        pace_sender();
    endtask

    // Drop valid and hold the sender until every owed word has come out.
    task automatic hold_until_drained;
        int guard;
        guard = 0;
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    // Receiver stall generator: always ready, coin flip, or a rotating pattern.
    always @(negedge i_clk) begin
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: begin
                m_tready      <= stall_pattern[0];
                stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
            end
        endcase
    end

    // Compare each accepted output word with the oldest owed word.
    always @(posedge i_clk) begin
        t_rx_word want;
        if (rst_n && o_m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("word with nothing owed", o_m_tdata[SEQ_W +: PAYLOAD_W], '0);
            end else begin
                want = pending_words.pop_front();
                if (o_m_tuser !== want.kind)
                    report_mismatch("kind", PAYLOAD_W'(o_m_tuser), PAYLOAD_W'(want.kind));
                if (o_m_tdata[SEQ_W-1:0] !== want.ack_num)
                    report_mismatch("ack_num", PAYLOAD_W'(o_m_tdata[SEQ_W-1:0]),
                                    PAYLOAD_W'(want.ack_num));
                if (o_m_tdata[SEQ_W +: PAYLOAD_W] !== want.data)
                    report_mismatch("payload_out", o_m_tdata[SEQ_W +: PAYLOAD_W], want.data);
                if (o_m_tdata[OUT_DATA_W-1 -: OUT_PAD_W] !== '0)
                    report_mismatch("tdata pad",
                                    PAYLOAD_W'(o_m_tdata[OUT_DATA_W-1 -: OUT_PAD_W]), '0);
                if (o_m_tlast !== want.last)
                    report_mismatch("last", PAYLOAD_W'(o_m_tlast), PAYLOAD_W'(want.last));
                if (want.kind == KIND_ACK)
                    acks_seen++;
                else
                    payloads_seen++;
            end
        end
    end

    // Hand-picked packets: corrupt drop, in-order delivery, previous-window
    // re-ack, duplicates keeping the first copy, two full eight-slot drains
    // (one wrapping the sequence space), all sequence numbers and payload extremes.
    task automatic test_directed;
        rx_mode   = 0;
        pacing_on = 1'b0;
        send_packet(1'b0, 4'd0, '1);
        send_packet(1'b1, 4'd0, '1);
        send_packet(1'b1, 4'd0, '0);
        send_packet(1'b1, 4'd9, 64'h0123_4567_89AB_CDEF);
        send_packet(1'b1, 4'd3, '0);
        send_packet(1'b1, 4'd2, 64'hAAAA_AAAA_AAAA_AAAA);
        send_packet(1'b1, 4'd2, 64'h5555_5555_5555_5555);
        send_packet(1'b0, 4'd1, '1);
        for (int s = 4; s <= 8; s++)
            send_packet(1'b1, SEQ_W'(s), {16{SEQ_W'(s)}});
        send_packet(1'b1, 4'd1, 64'h8000_0000_0000_0001);
        for (int s = 10; s <= 16; s++)
            send_packet(1'b1, SEQ_W'(s % SEQ_SPACE), ~{16{SEQ_W'(s)}});
        send_packet(1'b1, 4'd9, 64'h5555_5555_5555_5555);
        hold_until_drained();
    endtask

    // Rounds of a full or partial window sent out of order, with lost,
    // corrupted, duplicated and previous-window packets mixed in.
    task automatic test_windowed_traffic(input int n_items, input int mode, input bit paced);
        logic [SEQ_W-1:0] order[$];
        logic [SEQ_W-1:0] tmp;
        int               sent;
        int               run;
        int               j;
        rx_mode       = mode;
        stall_pattern = 8'($urandom) | 8'h01;
        pacing_on     = paced;
        sent          = 0;
        while (sent < n_items) begin
            run = $urandom_range(1, WIN);
            order.delete();
            for (int k = 0; k < run; k++)
                order.push_back(SEQ_W'((rx_base + k) % SEQ_SPACE));
            for (int k = run - 1; k > 0; k--) begin
                j        = $urandom_range(0, k);
                tmp      = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
            for (int k = 0; k < run; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_packet(1'b0, SEQ_W'($urandom), random_payload());
                    sent++;
                end
                // drop this packet now and then; the sender resends it next round
                if ($urandom_range(0, 15) != 0) begin
                    send_packet(1'b1, order[k], random_payload());
                    sent++;
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_packet(1'b1, order[$urandom_range(0, k)], random_payload());
                    sent++;
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_packet(1'b1,
                        SEQ_W'((rx_base + SEQ_SPACE - $urandom_range(1, WIN)) % SEQ_SPACE),
                        random_payload());
                    sent++;
                end
            end
            if ($urandom_range(0, 5) == 0)
                hold_until_drained();
        end
        hold_until_drained();
    endtask

    // Fully random packets.
    task automatic test_random_noise(input int n_items);
        rx_mode   = 1;
        pacing_on = 1'b1;
        for (int k = 0; k < n_items; k++)
            send_packet(1'($urandom_range(0, 3) != 0), SEQ_W'($urandom), random_payload());
        hold_until_drained();
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        rst_n <= 1'b1;
        test_directed();
        test_windowed_traffic(150, 2, 1'b1);
        test_windowed_traffic(130, 1, 1'b0);
        test_random_noise(60);
        if (pending_words.size() != 0)
            report_mismatch("words never delivered", PAYLOAD_W'(pending_words.size()), '0);
        $display("Sent %0d packets (%0d corrupt); checked %0d acks and %0d delivered payloads.",
                 items_taken, corrupt_taken, acks_seen, payloads_seen);
        $display("Covered out-of-order windows, duplicates, losses, re-acks and output stalls.");
        if (error_count == 0)
            $display("** selective_repeat_receiver: PASSED **");
        else
            $display("** selective_repeat_receiver: FAILED **");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d words still owed.", pending_words.size());
        $display("** selective_repeat_receiver: FAILED **");
        $finish;
    end

endmodule
